// File: sv/srxem_pkg.sv
`timescale 1ns / 1ps
// srxem_pkg: shared constants, register indexes and item types for the
// serial receive error marking block. No dependencies.
package srxem_pkg;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned MARK_W     = IDX_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // minimum free slots needed to take a character
  localparam logic [IDX_W-1:0]  MIN_ROOM       = IDX_W'(3);
  localparam logic [7:0]        MARK_BYTE      = 8'hff;
  localparam logic [7:0]        MARK_ZERO      = 8'h00;
  localparam logic [MARK_W-1:0] LOW_MARK_RESET = MARK_W'(16);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_BREAK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_INTERRUPT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_PARITY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_PARITY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECURE_ATTENTION  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_LOW_MARK = 3'd5;

  typedef struct packed {
    logic [7:0]       rx_byte;
    logic             break_seen;
    logic             framing_error;
    logic             parity_error;
    logic [IDX_W-1:0] reader_position;
  } rx_item_t;

  typedef struct packed {
    logic             store_valid;
    logic [7:0]       store_byte;
    logic [IDX_W-1:0] store_index;
    logic             last_of_run;
    logic             attention_event;
    logic             break_event;
    logic             dropped;
    logic             throttle_request;
  } ring_item_t;

endpackage

// File: sv/srxem_if.sv
`timescale 1ns / 1ps
// srxem interfaces: valid/ready channels for received characters, ring
// results and register writes. Depends on srxem_pkg.
interface srxem_rx_if import srxem_pkg::*; ();
  logic     valid;
  logic     ready;
  rx_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srxem_ring_if import srxem_pkg::*; ();
  logic       valid;
  logic       ready;
  ring_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srxem_cfg_if import srxem_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/serial_rx_error_marking.sv
`timescale 1ns / 1ps
// serial_rx_error_marking: receive conditioning for one serial line.
// Each character passes the decode register, then the result register. Throughput:
// one result per cycle while the receiver accepts; a character giving k results
// (1 to 3) holds the decode register until its last result is loaded. Reset:
// asynchronous, active low; clears the write position, valids and configuration
// registers (low mark to 16). Depends on srxem_pkg and the srxem interfaces.
module serial_rx_error_marking import srxem_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  srxem_cfg_if.sink      cfg_i,
  srxem_rx_if.sink       items_i,
  srxem_ring_if.source   results_o
);

  // configuration registers
  logic              ignore_break_q, break_interrupt_q, ignore_parity_q;
  logic              mark_parity_q, secure_attention_q;
  logic [MARK_W-1:0] low_mark_q;

  // ring write position
  logic [IDX_W-1:0] wr_q, wr_d;

  // decode register: holds the character while its results go out
  logic       s1_valid_q;
  rx_item_t   s1_item_q;
  logic [1:0] idx_q, idx_d;

  // result register
  logic       out_valid_q;
  ring_item_t out_item_q;

  logic             out_load, s1_done, in_take;
  logic [IDX_W-1:0] free_now, free_after, wr_after;
  logic             no_room, has_err, brk_store_zero, drop;
  logic             attn, bev, thr, is_last;
  logic [7:0]       ch_eff, res_byte;
  logic [1:0]       n_bytes, n_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_break_q     <= 1'b0;
      break_interrupt_q  <= 1'b0;
      ignore_parity_q    <= 1'b0;
      mark_parity_q      <= 1'b0;
      secure_attention_q <= 1'b0;
      low_mark_q         <= LOW_MARK_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IGNORE_BREAK:      ignore_break_q     <= cfg_i.data[0];
        CFG_BREAK_INTERRUPT:   break_interrupt_q  <= cfg_i.data[0];
        CFG_IGNORE_PARITY:     ignore_parity_q    <= cfg_i.data[0];
        CFG_MARK_PARITY:       mark_parity_q      <= cfg_i.data[0];
        CFG_SECURE_ATTENTION:  secure_attention_q <= cfg_i.data[0];
        CFG_THROTTLE_LOW_MARK: low_mark_q         <= cfg_i.data[MARK_W-1:0];
        default: ;
      endcase
    end
  end

  // free slots, ring depth is a power of two so the wrap is free
  assign free_now = s1_item_q.reader_position - wr_q - IDX_W'(1);
  assign no_room  = free_now < MIN_ROOM;
  assign has_err  = s1_item_q.break_seen | s1_item_q.framing_error | s1_item_q.parity_error;

  // plain break with no special handling stores a zero
  assign brk_store_zero = s1_item_q.break_seen & ~secure_attention_q & ~ignore_break_q
                          & ~break_interrupt_q;

  always_comb begin
    drop = no_room;
    if (!no_room && has_err) begin
      if (s1_item_q.break_seen) begin
        drop = ~secure_attention_q & ignore_break_q;
      end else begin
        drop = ignore_parity_q;
      end
    end
  end

  assign attn = ~no_room & s1_item_q.break_seen & secure_attention_q;
  assign bev  = ~no_room & s1_item_q.break_seen & ~secure_attention_q & ~ignore_break_q
                & break_interrupt_q;

  // byte actually stored for the character itself
  always_comb begin
    ch_eff = s1_item_q.rx_byte;
    if (has_err && (!mark_parity_q || brk_store_zero)) begin
      ch_eff = MARK_ZERO;
    end
  end

  // ring bytes for this character: error mark takes three, escaped 0xff two
  always_comb begin
    if (drop) begin
      n_bytes = 2'd0;
    end else if (has_err) begin
      n_bytes = mark_parity_q ? 2'd3 : 2'd1;
    end else if (mark_parity_q && s1_item_q.rx_byte == MARK_BYTE) begin
      n_bytes = 2'd2;
    end else begin
      n_bytes = 2'd1;
    end
  end

  assign n_res      = drop ? 2'd1 : n_bytes;
  assign is_last    = idx_q == (n_res - 2'd1);
  assign wr_after   = wr_q + IDX_W'(n_bytes);
  assign free_after = s1_item_q.reader_position - wr_after - IDX_W'(1);
  assign thr        = {1'b0, free_after} < low_mark_q;

  // prefix bytes: 0xff,0x00 ahead of an error, 0xff ahead of an escaped 0xff
  always_comb begin
    if (is_last) begin
      res_byte = ch_eff;
    end else if (has_err && idx_q != 2'd0) begin
      res_byte = MARK_ZERO;
    end else begin
      res_byte = MARK_BYTE;
    end
  end

  assign out_load      = s1_valid_q & (~out_valid_q | results_o.ready);
  assign s1_done       = out_load & is_last;
  assign items_i.ready = ~s1_valid_q | s1_done;
  assign in_take       = items_i.valid & items_i.ready;
  assign idx_d         = s1_done ? 2'd0 : (out_load ? idx_q + 2'd1 : idx_q);
  assign wr_d          = s1_done ? wr_after : wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      idx_q       <= 2'd0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      wr_q  <= wr_d;
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (results_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= items_i.data;
    end
    if (out_load) begin
      if (drop) begin
        out_item_q.store_valid     <= 1'b0;
        out_item_q.store_byte      <= '0;
        out_item_q.store_index     <= '0;
        out_item_q.attention_event <= 1'b0;
        out_item_q.break_event     <= 1'b0;
        out_item_q.dropped         <= 1'b1;
      end else begin
        out_item_q.store_valid     <= 1'b1;
        out_item_q.store_byte      <= res_byte;
        out_item_q.store_index     <= wr_q + IDX_W'(idx_q);
        out_item_q.attention_event <= is_last & attn;
        out_item_q.break_event     <= is_last & bev;
        out_item_q.dropped         <= 1'b0;
      end
      out_item_q.last_of_run      <= is_last;
      // drop leaves the write position alone, so free_after equals free_now
      out_item_q.throttle_request <= thr;
    end
  end

  assign results_o.valid = out_valid_q;
  assign results_o.data  = out_item_q;

endmodule

// File: test/serial_rx_error_marking_tb.sv
`timescale 1ns / 1ps
// serial_rx_error_marking_tb: directed and random checks of the receive conditioning
// block against a behavioural predictor, under random idling and a long receiver hold-off.
// Depends on srxem_pkg, the srxem interfaces and serial_rx_error_marking.
module serial_rx_error_marking_tb;
  import srxem_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int IDLE_PCT    = 12;
  // longest receiver hold-off, well inside the watchdog window
  localparam int HOLD_CYCLES = 80;
  // cycles with no item moving on any channel before the run is called hung
  localparam int STALL_LIMIT = 2000;
  localparam int SHOW_MAX    = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  srxem_cfg_if  cfg_bus ();
  srxem_rx_if   rx_bus ();
  srxem_ring_if ring_bus ();

  serial_rx_error_marking i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_bus),
    .items_i   (rx_bus),
    .results_o (ring_bus)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // shadow copy of the block's registers and ring write position
  bit               cfg_ignore_break;
  bit               cfg_break_irq;
  bit               cfg_ignore_parity;
  bit               cfg_mark_parity;
  bit               cfg_secure_attn;
  logic [MARK_W-1:0] cfg_low_mark = LOW_MARK_RESET;
  logic [IDX_W-1:0]  ring_wr_pos;

  // ring writes still owed by the block, oldest first
  ring_item_t ring_writes_due[$];

  bit no_idle;       // both sides offer and accept every cycle
  bit hold_off_req;  // ask the receiver for one long hold-off
  int mismatches;
  int idle_cycles;

  // free ring slots; 10-bit arithmetic gives the modulo for free
  function automatic logic [IDX_W-1:0] ring_free(logic [IDX_W-1:0] rd, logic [IDX_W-1:0] wr);
    return rd - wr - IDX_W'(1);
  endfunction

  // works out the ring writes one accepted character causes, in order
  function automatic void condition_char(rx_item_t c);
    logic [7:0]       seq [3];
    int               n;
    bit               drop;
    bit               attn;
    bit               brk_ev;
    bit               thr;
    logic [7:0]       ch;
    logic [IDX_W-1:0] wr;
    ring_item_t       r;
    n      = 0;
    drop   = 1'b0;
    attn   = 1'b0;
    brk_ev = 1'b0;
    ch     = c.rx_byte;
    wr     = ring_wr_pos;
    if (ring_free(c.reader_position, wr) < MIN_ROOM) begin
      drop = 1'b1;
    end else if (c.break_seen || c.framing_error || c.parity_error) begin
      // a break takes its own rules; ignore-parity does not apply to it
      if (c.break_seen) begin
        if (cfg_secure_attn) attn = 1'b1;
        else if (cfg_ignore_break) drop = 1'b1;
        else if (cfg_break_irq) brk_ev = 1'b1;
        else ch = MARK_ZERO;
      end else if (cfg_ignore_parity) begin
        drop = 1'b1;
      end
      if (!drop) begin
        if (cfg_mark_parity) begin
          seq[n] = MARK_BYTE;
          n++;
          seq[n] = MARK_ZERO;
          n++;
        end else begin
          ch = MARK_ZERO;
        end
        seq[n] = ch;
        n++;
      end
    end else begin
      // clean data 0xff is doubled when marking is on
      if (cfg_mark_parity && ch == MARK_BYTE) begin
        seq[n] = MARK_BYTE;
        n++;
      end
      seq[n] = ch;
      n++;
    end

    if (drop) begin
      r = '0;
      r.last_of_run      = 1'b1;
      r.dropped          = 1'b1;
      r.throttle_request = {1'b0, ring_free(c.reader_position, wr)} < cfg_low_mark;
      ring_writes_due.push_back(r);
      return;
    end

    // throttle judged on the room left once the whole character is in
    thr = {1'b0, ring_free(c.reader_position, wr + IDX_W'(n))} < cfg_low_mark;
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.store_valid      = 1'b1;
      r.store_byte       = seq[k];
      r.store_index      = wr;
      r.last_of_run      = (k == n - 1);
      r.attention_event  = (k == n - 1) && attn;
      r.break_event      = (k == n - 1) && brk_ev;
      r.throttle_request = thr;
      ring_writes_due.push_back(r);
      wr = wr + IDX_W'(1);
    end
    ring_wr_pos = wr;
  endfunction

  function automatic string ring_text(ring_item_t r);
    return $sformatf("valid=%0b byte=%02h idx=%0d last=%0b attn=%0b brk=%0b drop=%0b thr=%0b",
                     r.store_valid, r.store_byte, r.store_index, r.last_of_run,
                     r.attention_event, r.break_event, r.dropped, r.throttle_request);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // compare one ring item with the oldest one owed
  task automatic check_ring_item(ring_item_t got);
    ring_item_t want;
    if (ring_writes_due.size() == 0) begin
      note_mismatch({"ring item with none owed: ", ring_text(got)});
      return;
    end
    want = ring_writes_due.pop_front();
    if (got.store_valid      !== want.store_valid      ||
        got.store_byte       !== want.store_byte       ||
        got.store_index      !== want.store_index      ||
        got.last_of_run      !== want.last_of_run      ||
        got.attention_event  !== want.attention_event  ||
        got.break_event      !== want.break_event      ||
        got.dropped          !== want.dropped          ||
        got.throttle_request !== want.throttle_request)
      note_mismatch({"expected ", ring_text(want), " got ", ring_text(got)});
  endtask

  // results are sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && ring_bus.valid && ring_bus.ready) check_ring_item(ring_bus.data);
  end

  // watchdog: counts cycles in which no item moves on any channel
  always @(posedge clk_i) begin
    if ((rx_bus.valid && rx_bus.ready) || (ring_bus.valid && ring_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, a steady stretch, and one long hold-off on request
  initial begin
    ring_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        ring_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      ring_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // offer one character, with a random gap first, and predict it once taken
  task automatic send_char(rx_item_t c);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(3, 1);
    @(negedge clk_i);
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_bus.valid <= 1'b1;
    rx_bus.data  <= c;
    do @(posedge clk_i); while (!rx_bus.ready);
    condition_char(c);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_IGNORE_BREAK:      cfg_ignore_break  = val[0];
      CFG_BREAK_INTERRUPT:   cfg_break_irq     = val[0];
      CFG_IGNORE_PARITY:     cfg_ignore_parity = val[0];
      CFG_MARK_PARITY:       cfg_mark_parity   = val[0];
      CFG_SECURE_ATTENTION:  cfg_secure_attn   = val[0];
      CFG_THROTTLE_LOW_MARK: cfg_low_mark      = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // stop offering and let every owed ring item arrive
  task automatic settle();
    @(negedge clk_i);
    rx_bus.valid <= 1'b0;
    while (ring_writes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(bit ib, bit bi, bit ip, bit mp, bit sa, logic [MARK_W-1:0] lm);
    settle();
    write_reg(CFG_IGNORE_BREAK, CFG_DATA_W'(ib));
    write_reg(CFG_BREAK_INTERRUPT, CFG_DATA_W'(bi));
    write_reg(CFG_IGNORE_PARITY, CFG_DATA_W'(ip));
    write_reg(CFG_MARK_PARITY, CFG_DATA_W'(mp));
    write_reg(CFG_SECURE_ATTENTION, CFG_DATA_W'(sa));
    write_reg(CFG_THROTTLE_LOW_MARK, lm);
  endtask

  // character whose reader position leaves exactly 'room' free slots
  function automatic rx_item_t char_at_room(logic [7:0] b, bit brk, bit fe, bit pe, int room);
    rx_item_t c;
    c.rx_byte         = b;
    c.break_seen      = brk;
    c.framing_error   = fe;
    c.parity_error    = pe;
    c.reader_position = ring_wr_pos + IDX_W'(1) + IDX_W'(room);
    return c;
  endfunction

  // random character: room mostly plentiful, some near full and near the low mark
  function automatic rx_item_t random_char();
    int pick;
    int room;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 8) room = $urandom_range(2);
    else if (pick < 16) room = $urandom_range(5, 3);
    else if (pick < 36) begin
      room = int'(cfg_low_mark) + $urandom_range(7) - 4;
      if (room < 0) room = 0;
      if (room > RING_DEPTH - 1) room = RING_DEPTH - 1;
    end else room = $urandom_range(RING_DEPTH - 1);
    pick = $urandom_range(99);
    if (pick < 15) b = MARK_BYTE;
    else if (pick < 22) b = MARK_ZERO;
    else b = 8'($urandom_range(255));
    return char_at_room(b, $urandom_range(99) < 15, $urandom_range(99) < 15,
                        $urandom_range(99) < 15, room);
  endfunction

  // reset settings: plain data, room limits, throttle edge, unmarked errors
  task automatic test_plain_and_room();
    send_char(char_at_room(8'h00, 0, 0, 0, 1000));
    send_char(char_at_room(8'hff, 0, 0, 0, 1000));
    send_char(char_at_room(8'h5a, 0, 0, 0, 0));     // ring full
    send_char(char_at_room(8'h5a, 0, 0, 0, 2));     // one short of room
    send_char(char_at_room(8'h5b, 0, 0, 0, 3));     // just fits, throttles
    send_char(char_at_room(8'h5c, 0, 0, 0, 20));
    send_char(char_at_room(8'h5d, 0, 0, 0, 16));    // lands one under the mark
    send_char(char_at_room(8'ha5, 1, 0, 0, 500));   // plain break stores zero
    send_char(char_at_room(8'h3c, 0, 1, 0, 500));
    send_char(char_at_room(8'hc3, 0, 0, 1, 500));
    send_char(char_at_room(8'hff, 1, 1, 1, 500));
  endtask

  // marking on, ignore rules and the break priority chain
  task automatic test_error_marking();
    apply_config(0, 0, 1, 1, 0, LOW_MARK_RESET);
    send_char(char_at_room(8'hff, 0, 0, 0, 500));   // escaped data byte
    send_char(char_at_room(8'h11, 0, 0, 1, 500));   // parity error ignored
    send_char(char_at_room(8'h22, 1, 0, 1, 500));   // break beats ignore-parity
    send_char(char_at_room(8'hff, 0, 0, 0, 2));
    apply_config(1, 1, 0, 1, 1, LOW_MARK_RESET);
    send_char(char_at_room(8'h33, 1, 0, 0, 500));   // attention wins over ignore
    send_char(char_at_room(8'h44, 0, 1, 0, 3));     // three marked bytes fill it
    apply_config(1, 1, 0, 1, 0, LOW_MARK_RESET);
    send_char(char_at_room(8'h55, 1, 0, 0, 500));   // break ignored
    apply_config(0, 1, 0, 1, 0, LOW_MARK_RESET);
    send_char(char_at_room(8'h66, 1, 0, 0, 500));   // break event, marked
    apply_config(0, 1, 0, 0, 0, LOW_MARK_RESET);
    send_char(char_at_room(8'h77, 1, 0, 0, 500));   // break event, stored as zero
  endtask

  // random settings and traffic; a negative low mark means pick one at random
  task automatic test_random_traffic(int count, bit steady, int low_mark);
    logic [MARK_W-1:0] lm;
    if (low_mark < 0) lm = $urandom_range(1) ? MARK_W'($urandom_range(1024))
                                               : MARK_W'($urandom_range(40));
    else lm = MARK_W'(low_mark);
    apply_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)), lm);
    no_idle = steady;
    repeat (count) send_char(random_char());
    no_idle = 1'b0;
  endtask

  // receiver holds off while characters keep coming, so the input backs up
  task automatic test_receiver_hold_off();
    apply_config(0, 1, 0, 1, 0, LOW_MARK_RESET);
    hold_off_req = 1'b1;
    repeat (24) send_char(random_char());
  endtask

  initial begin
    rx_bus.valid  = 1'b0;
    rx_bus.data   = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    ring_wr_pos   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_and_room();
    test_error_marking();
    test_random_traffic(60, 1'b0, 0);     // throttle never asked
    test_random_traffic(60, 1'b0, 1024);  // throttle always asked
    test_random_traffic(90, 1'b1, -1);    // steady stretch, no idling
    test_receiver_hold_off();
    repeat (3) test_random_traffic(70, 1'b0, -1);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && ring_writes_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/srxem_pkg.sv
sv/srxem_if.sv
sv/serial_rx_error_marking.sv
test/serial_rx_error_marking_tb.sv
